FILE: design/i2cmts_pkg.sv
// Package for the I2C master transfer sequencer: transaction payload types,
// request and status codes, and transmit buffer sizing.
// No dependencies.
`default_nettype none

package i2cmts_pkg;

	// Transmit buffer geometry (depth is a power of two)
	localparam int BUF_DEPTH = 256;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int LEN_W     = 9;
	localparam int IDX_CMP_W = 13;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_EVENT = 2'd1,
		REQ_ABORT = 2'd2,
		REQ_LOAD  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		START_NONE   = 2'd0,
		START_COND   = 2'd1,
		START_REPEAT = 2'd2
	} start_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NACK  = 2'd1,
		ST_NOSYS = 2'd2,
		ST_ABORT = 2'd3
	} status_t;

	typedef struct packed {
		req_kind_t        req_type;
		logic [7:0]       slave_addr;
		logic             is_read;
		logic             is_ten_bit;
		logic [LEN_W-1:0] msg_len;
		logic             send_stop;
		logic             xfer_complete;
		logic             nack_seen;
		logic [7:0]       rx_data;
		logic [7:0]       load_index;
		logic [7:0]       load_value;
	} req_t;

	typedef struct packed {
		start_kind_t start_kind;
		logic        drive_data;
		logic [7:0]  data_out;
		logic        release_bus;
		logic        no_ack_next;
		logic        switch_to_rx;
		logic        rx_valid;
		logic [7:0]  rx_byte;
		logic [7:0]  byte_index;
		logic        irq_enable;
		logic        done_res;
		status_t     status;
	} rsp_t;

	// Buffer port request from the sequencer to the buffer memory
	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [BUF_AW-1:0] wr_addr;
		logic [BUF_AW-1:0] rd_addr;
		logic [7:0]        wr_data;
	} buf_req_t;

endpackage

`default_nettype wire

FILE: design/i2cmts_txbuf.sv
// Transmit byte buffer: one write port and one registered read port.
// Depends on i2cmts_pkg.
`default_nettype none

module i2cmts_txbuf (
	input  wire logic                 clk,
	input  wire i2cmts_pkg::buf_req_t breq,
	output logic [7:0]                rdata
);

	logic [7:0] mem [i2cmts_pkg::BUF_DEPTH];
	logic [7:0] rdata_q;

	// Write loaded bytes
	always_ff @(posedge clk) begin
		if (breq.wr_en) begin
			mem[breq.wr_addr] <= breq.wr_data;
		end
	end

	// Registered read; hold while no read is issued
	always_ff @(posedge clk) begin
		if (breq.rd_en) begin
			rdata_q <= mem[breq.rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: design/i2cmts_ctrl.sv
// Transfer sequencer core: mode and position registers, per-transaction step
// logic, buffer port requests and the first pipeline stage. Depends on i2cmts_pkg.
`default_nettype none

module i2cmts_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire i2cmts_pkg::req_t     req,
	input  wire logic                 adv_s1,
	output logic                      valid_s1,
	output logic                      use_mem_s1,
	output i2cmts_pkg::rsp_t          res_s1,
	output i2cmts_pkg::buf_req_t      breq
);

	localparam int LW = i2cmts_pkg::LEN_W;

	logic          active_q, read_mode_q, stop_at_end_q;
	logic [LW-1:0] length_q, position_q;
	logic          addr_phase_q, master_mode_q, irq_on_q;

	logic          active_d, read_mode_d, stop_at_end_d;
	logic [LW-1:0] length_d, position_d;
	logic          addr_phase_d, master_mode_d, irq_on_d;

	logic             accept;
	logic             use_mem;
	logic [LW-1:0]    pos_inc;
	logic [LW-1:0]    rest;
	logic             load_in_range;
	i2cmts_pkg::rsp_t res;

	assign req_ready = !valid_s1 || adv_s1;
	assign accept    = req_valid && req_ready;
	assign pos_inc   = position_q + LW'(1);
	assign rest      = length_q - position_q;
	assign load_in_range = IDX_CMP_W_CHECK(req.load_index);

	function automatic logic IDX_CMP_W_CHECK(input logic [7:0] idx);
		logic [i2cmts_pkg::IDX_CMP_W-1:0] ext;
		ext = i2cmts_pkg::IDX_CMP_W'(idx);
		return ext < i2cmts_pkg::IDX_CMP_W'(i2cmts_pkg::BUF_DEPTH);
	endfunction

	// Step one transaction: controller actions and next mode state
	always_comb begin
		res           = '0;
		use_mem       = 1'b0;
		active_d      = active_q;
		read_mode_d   = read_mode_q;
		stop_at_end_d = stop_at_end_q;
		length_d      = length_q;
		position_d    = position_q;
		addr_phase_d  = addr_phase_q;
		master_mode_d = master_mode_q;
		irq_on_d      = irq_on_q;

		unique case (req.req_type)
			i2cmts_pkg::REQ_START: begin
				res.start_kind = master_mode_q ? i2cmts_pkg::START_REPEAT
				                               : i2cmts_pkg::START_COND;
				master_mode_d = 1'b1;
				addr_phase_d  = 1'b1;
				active_d      = 1'b0;
				if (req.msg_len == '0) begin
					master_mode_d   = 1'b0;
					res.release_bus = 1'b1;
					res.done_res    = 1'b1;
					res.status      = i2cmts_pkg::ST_OK;
				end else if (req.is_ten_bit) begin
					master_mode_d   = 1'b0;
					res.release_bus = 1'b1;
					res.done_res    = 1'b1;
					res.status      = i2cmts_pkg::ST_NOSYS;
				end else begin
					active_d       = 1'b1;
					read_mode_d    = req.is_read;
					stop_at_end_d  = req.send_stop;
					length_d       = req.msg_len;
					position_d     = '0;
					res.drive_data = 1'b1;
					irq_on_d       = 1'b1;
					if (req.is_read) begin
						res.no_ack_next = (req.msg_len <= LW'(1));
						res.data_out    = {req.slave_addr[7:1], 1'b1};
					end else begin
						res.data_out    = {req.slave_addr[7:1], 1'b0};
					end
				end
			end
			i2cmts_pkg::REQ_EVENT: begin
				if (!irq_on_q) begin
					// interrupts off: ignore
				end else if (!active_q) begin
					master_mode_d   = 1'b0;
					res.release_bus = 1'b1;
				end else if (read_mode_q) begin
					if (!req.xfer_complete) begin
						// read ignores events without the complete flag
					end else if (addr_phase_q) begin
						if (req.nack_seen) begin
							irq_on_d     = 1'b0;
							active_d     = 1'b0;
							res.done_res = 1'b1;
							res.status   = i2cmts_pkg::ST_NACK;
						end else begin
							addr_phase_d     = 1'b0;
							res.switch_to_rx = 1'b1;
						end
					end else begin
						if (rest == LW'(2)) begin
							res.no_ack_next = 1'b1;
						end else if (rest == LW'(1)) begin
							master_mode_d   = 1'b0;
							res.release_bus = 1'b1;
						end
						res.rx_valid   = 1'b1;
						res.rx_byte    = req.rx_data;
						res.byte_index = position_q[7:0];
						position_d     = pos_inc;
						if (pos_inc == length_q) begin
							active_d     = 1'b0;
							res.done_res = 1'b1;
							res.status   = i2cmts_pkg::ST_OK;
						end
					end
				end else begin
					if (req.xfer_complete && !req.nack_seen) begin
						if (position_q == length_q) begin
							if (stop_at_end_q) begin
								master_mode_d   = 1'b0;
								res.release_bus = 1'b1;
							end
							irq_on_d     = 1'b0;
							active_d     = 1'b0;
							res.done_res = 1'b1;
							res.status   = i2cmts_pkg::ST_OK;
						end else begin
							// data byte comes from the buffer read
							res.drive_data = 1'b1;
							use_mem        = 1'b1;
							position_d     = pos_inc;
						end
					end else begin
						irq_on_d     = 1'b0;
						active_d     = 1'b0;
						res.done_res = 1'b1;
						res.status   = i2cmts_pkg::ST_NACK;
					end
				end
			end
			i2cmts_pkg::REQ_ABORT: begin
				if (active_q) begin
					res.done_res = 1'b1;
					res.status   = i2cmts_pkg::ST_ABORT;
				end
				active_d        = 1'b0;
				master_mode_d   = 1'b0;
				irq_on_d        = 1'b0;
				addr_phase_d    = 1'b0;
				position_d      = '0;
				res.release_bus = 1'b1;
			end
			i2cmts_pkg::REQ_LOAD: begin
				// buffer write only
			end
			default: begin
			end
		endcase
		res.irq_enable = irq_on_d;
	end

	// Drive the buffer ports: write on load, read at current position
	always_comb begin
		breq.wr_en   = accept && (req.req_type == i2cmts_pkg::REQ_LOAD) && load_in_range;
		breq.wr_addr = i2cmts_pkg::BUF_AW'(req.load_index);
		breq.wr_data = req.load_value;
		breq.rd_en   = accept && use_mem;
		breq.rd_addr = i2cmts_pkg::BUF_AW'(position_q);
	end

	// Update mode state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			read_mode_q   <= 1'b0;
			stop_at_end_q <= 1'b0;
			length_q      <= '0;
			position_q    <= '0;
			addr_phase_q  <= 1'b0;
			master_mode_q <= 1'b0;
			irq_on_q      <= 1'b0;
		end else if (accept) begin
			active_q      <= active_d;
			read_mode_q   <= read_mode_d;
			stop_at_end_q <= stop_at_end_d;
			length_q      <= length_d;
			position_q    <= position_d;
			addr_phase_q  <= addr_phase_d;
			master_mode_q <= master_mode_d;
			irq_on_q      <= irq_on_d;
		end
	end

	// Stage 1 valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload, aligned with the buffer read data
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1     <= res;
			use_mem_s1 <= use_mem;
		end
	end

endmodule

`default_nettype wire

FILE: design/i2c_master_transfer_sequencer.sv
// Top level of the I2C master transfer sequencer: sequencer core, transmit
// buffer memory and result output register. Depends on i2cmts_pkg, i2cmts_ctrl, i2cmts_txbuf.
`default_nettype none

// Each accepted request transaction (start, byte-complete event, abort or
// buffer load) yields exactly one result transaction, in order. A request
// is taken every cycle while results are taken; its result is registered in
// stage 1, with the sequencer step and the synchronous transmit buffer read,
// then in the output register. While a result waits on rsp_ready, one more
// request enters the first stage; the input then stalls until the result
// is taken. The buffer needs no clearing pass; unwritten entries read as
// undefined.
module i2c_master_transfer_sequencer (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire i2cmts_pkg::req_t req,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output i2cmts_pkg::rsp_t      rsp
);

	logic                 valid_s1, use_mem_s1, adv_s1;
	i2cmts_pkg::rsp_t     res_s1;
	i2cmts_pkg::rsp_t     res_merged;
	i2cmts_pkg::buf_req_t breq;
	logic [7:0]           rdata;
	logic                 rsp_valid_q;
	i2cmts_pkg::rsp_t     rsp_q;

	assign adv_s1 = valid_s1 && (!rsp_valid_q || rsp_ready);

	i2cmts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.adv_s1     (adv_s1),
		.valid_s1   (valid_s1),
		.use_mem_s1 (use_mem_s1),
		.res_s1     (res_s1),
		.breq       (breq)
	);

	i2cmts_txbuf u_txbuf (
		.clk   (clk),
		.breq  (breq),
		.rdata (rdata)
	);

	// Hold the output valid until the result transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Merge buffer data into the result
	always_comb begin
		res_merged = res_s1;
		if (use_mem_s1) begin
			res_merged.data_out = rdata;
		end
	end

	// Load the output register as the first stage advances
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= res_merged;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: design/i2cmts_chk.sv
// Port-level checker for the I2C master transfer sequencer, bound to the top.
// Depends on i2cmts_pkg and i2c_master_transfer_sequencer.
`default_nettype none

module i2cmts_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_ready,
	input wire i2cmts_pkg::req_t req,
	input wire logic             rsp_valid,
	input wire logic             rsp_ready,
	input wire i2cmts_pkg::rsp_t rsp
);

	// A waiting request transaction holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// A stalled result transaction holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// Status is zero unless the transfer finished
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.done_res |-> rsp.status == i2cmts_pkg::ST_OK)
		else $error("status without done");

	// Received byte fields are zero without rx_valid
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.rx_valid |-> rsp.rx_byte == 8'd0 && rsp.byte_index == 8'd0)
		else $error("rx fields set without rx_valid");

	// A start either opens a transfer with interrupts on or finishes at once
	a_start_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.start_kind != i2cmts_pkg::START_NONE
		|-> rsp.irq_enable || (rsp.done_res && rsp.release_bus))
		else $error("start left neither open nor finished");

endmodule

bind i2c_master_transfer_sequencer i2cmts_chk u_chk (.*);

`default_nettype wire
